@@ src/column_similarity_engine_unit_macros.svh @@
// Assertion macros for the column similarity engine checker.
// Used by cse_checker only; no dependencies.
`ifndef COLUMN_SIMILARITY_ENGINE_UNIT_MACROS_SVH
`define COLUMN_SIMILARITY_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cse check failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cse check failed");

`endif

@@ src/cse_pkg.sv @@
// Shared constants, codes and types for the column similarity engine.
// No dependencies.
`default_nettype none
package cse_pkg;
    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;
    localparam int ADDR_W = $clog2(ROWS * COLS);
    localparam int RAT_W  = 8;
    localparam int RES_W  = 27;
    localparam int ACC_W  = 22;
    localparam int PROD_W = 44;
    localparam int NUM_W  = 38;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic [1:0] MET_MAN    = 2'd0;
    localparam logic [1:0] MET_EUC    = 2'd1;
    localparam logic [1:0] MET_COS    = 2'd2;
    localparam logic [1:0] MET_PEAR   = 2'd3;
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WRITE = 2'd1;
    localparam logic [1:0] STAT_UNDEF = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_POST,
        ST_PMUL, ST_PACC, ST_SQRT, ST_DIV, ST_OUT
    } state_t;
endpackage
`default_nettype wire

@@ src/column_similarity_engine_unit.sv @@
// Column similarity engine: rating store, shared multiplier, bit-serial
// square root and divider. Depends on cse_pkg.
//
// Usage: one input word on s_axis_*; tuser = cmd (0 write, 1 query).
// A write stores one Q4.4 rating and answers with status 1, result 0,
// in the cycle after acceptance. A query walks the 8 rows of two columns
// through one shared 22x22 multiplier (one pass per product); Euclidean,
// cosine and Pearson then run a one-bit-per-cycle square root, and cosine
// and Pearson a restoring divider after it. The multiplier passes per row
// and the serial root and divide set how long a query takes.
// One word is in flight at a time: s_axis_tready is high only while idle,
// so a new word is taken only after the last result word is handed over.
// The result word holds on m_axis_* until m_axis_tready; a stalled
// receiver simply holds the block. Reset clears the control state and
// the per-cell valid bits, so every cell reads as zero until written.
`default_nettype none
module column_similarity_engine_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // row, col_a, col_b, rating, metric, zero fill
    input  wire logic [cse_pkg::IN_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // result, status, zero fill
    output logic [cse_pkg::OUT_W-1:0]      m_axis_tdata
);
    import cse_pkg::*;

    state_t state_reg, state_next;

    logic [RAT_W-1:0]  mem [ROWS*COLS];
    logic [ROWS*COLS-1:0] valid_reg;

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_ca, in_cb;
    logic [RAT_W-1:0]  in_rating;
    logic [1:0]        in_metric;
    logic              accept;
    logic [ADDR_W-1:0] waddr, addr_a, addr_b;

    logic [COL_W-1:0]  ca_reg, cb_reg;
    logic [1:0]        metric_reg;
    logic [ROW_W:0]    row_cnt_reg;
    logic [1:0]        k_reg;
    logic [2:0]        step_reg;
    logic [RAT_W-1:0]  a_reg, b_reg, d;
    logic              co;
    logic [ACC_W-1:0]  x_reg, y_reg, p_reg, op_a, op_b;
    logic [ACC_W:0]    t_reg;
    logic [3:0]        n_reg;
    logic [11:0]       sx_reg, sy_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [PROD_W:0]   sq_sum;
    logic [NUM_W-1:0]  dv_num_reg;
    logic [ACC_W-1:0]  dv_rem_reg, dv_den_reg;
    logic [ACC_W:0]    dv_rem2;
    logic              dv_ge;
    logic [NUM_W-1:0]  dv_quot;
    logic [5:0]        dv_cnt_reg;
    logic signed [RES_W-1:0] res_reg;
    logic [1:0]        stat_reg;

    logic last_k, last_row, post_undef, pacc_undef, sq_last, dv_last;

    assign in_row    = s_axis_tdata[2:0];
    assign in_ca     = s_axis_tdata[5:3];
    assign in_cb     = s_axis_tdata[8:6];
    assign in_rating = s_axis_tdata[16:9];
    assign in_metric = s_axis_tdata[18:17];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {{(OUT_W-RES_W-2){1'b0}}, stat_reg, res_reg};

    assign waddr  = ADDR_W'(int'(in_row) * COLS + int'(in_ca));
    assign addr_a = ADDR_W'(int'(row_cnt_reg[ROW_W-1:0]) * COLS + int'(ca_reg));
    assign addr_b = ADDR_W'(int'(row_cnt_reg[ROW_W-1:0]) * COLS + int'(cb_reg));

    assign d  = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
    assign co = (a_reg != '0) && (b_reg != '0);

    assign last_k     = (metric_reg == MET_MAN || metric_reg == MET_EUC) ? (k_reg == 2'd0)
                                                                          : (k_reg == 2'd2);
    assign last_row   = (row_cnt_reg == (ROW_W+1)'(ROWS - 1));
    assign post_undef = (metric_reg == MET_COS) ? (x_reg == '0 || y_reg == '0)
                                                : (n_reg == '0);
    assign pacc_undef = (x_reg == '0) || (y_reg == '0);
    assign sq_sum     = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
    assign sq_last    = sq_bit_reg[0];
    assign dv_rem2    = {dv_rem_reg, dv_num_reg[NUM_W-1]};
    assign dv_ge      = (dv_rem2 >= {1'b0, dv_den_reg});
    assign dv_quot    = {dv_num_reg[NUM_W-2:0], dv_ge};
    assign dv_last    = (dv_cnt_reg == 6'(NUM_W - 1));

    // shared multiplier operands
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_MUL)
        begin
            unique case (metric_reg)
                MET_MAN: begin op_a = ACC_W'(d); op_b = ACC_W'(1); end
                MET_EUC: begin op_a = ACC_W'(d); op_b = ACC_W'(d); end
                default:
                begin
                    case (k_reg)
                        2'd0:    begin op_a = ACC_W'(a_reg); op_b = ACC_W'(b_reg); end
                        2'd1:    begin op_a = ACC_W'(a_reg); op_b = ACC_W'(a_reg); end
                        default: begin op_a = ACC_W'(b_reg); op_b = ACC_W'(b_reg); end
                    endcase
                end
            endcase
        end
        else
        begin
            case (step_reg)
                3'd0:    begin op_a = ACC_W'(n_reg);  op_b = x_reg;           end
                3'd1:    begin op_a = ACC_W'(sx_reg); op_b = ACC_W'(sx_reg);  end
                3'd2:    begin op_a = ACC_W'(n_reg);  op_b = y_reg;           end
                3'd3:    begin op_a = ACC_W'(sy_reg); op_b = ACC_W'(sy_reg);  end
                3'd4:    begin op_a = ACC_W'(n_reg);  op_b = p_reg;           end
                3'd5:    begin op_a = ACC_W'(sx_reg); op_b = ACC_W'(sy_reg);  end
                default: begin op_a = x_reg;          op_b = y_reg;           end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (s_axis_tuser == CMD_WRITE) ? ST_OUT : ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:
                if (!last_k)
                    state_next = ST_MUL;
                else if (last_row)
                    state_next = ST_POST;
                else
                    state_next = ST_READ;
            ST_POST:
                unique case (metric_reg)
                    MET_MAN: state_next = ST_OUT;
                    MET_EUC: state_next = ST_SQRT;
                    default: state_next = post_undef ? ST_OUT : ST_PMUL;
                endcase
            ST_PMUL: state_next = ST_PACC;
            ST_PACC:
                if (step_reg == 3'd6)
                    state_next = pacc_undef ? ST_OUT : ST_SQRT;
                else
                    state_next = ST_PMUL;
            ST_SQRT:
                if (sq_last)
                    state_next = (metric_reg == MET_EUC) ? ST_OUT : ST_DIV;
            ST_DIV:
                if (dv_last)
                    state_next = ST_OUT;
            ST_OUT:
                if (m_axis_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (accept && s_axis_tuser == CMD_WRITE
                 && int'(in_row) < ROWS && int'(in_ca) < COLS)
            valid_reg[waddr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == CMD_WRITE
            && int'(in_row) < ROWS && int'(in_ca) < COLS)
            mem[waddr] <= in_rating;
        if (state_reg == ST_READ)
        begin
            a_reg <= valid_reg[addr_a] ? mem[addr_a] : '0;
            b_reg <= valid_reg[addr_b] ? mem[addr_b] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                ca_reg      <= in_ca;
                cb_reg      <= in_cb;
                metric_reg  <= in_metric;
                row_cnt_reg <= '0;
                k_reg       <= '0;
                x_reg       <= '0;
                y_reg       <= '0;
                p_reg       <= '0;
                n_reg       <= '0;
                sx_reg      <= '0;
                sy_reg      <= '0;
                neg_reg     <= 1'b0;
                res_reg     <= '0;
                stat_reg    <= (s_axis_tuser == CMD_WRITE) ? STAT_WRITE : STAT_OK;
            end
            ST_READ: k_reg <= '0;
            ST_MUL:  prod_reg <= op_a * op_b;
            ST_ACC:
            begin
                if (metric_reg == MET_MAN || metric_reg == MET_EUC)
                    x_reg <= x_reg + prod_reg[ACC_W-1:0];
                else if (metric_reg == MET_COS || co)
                begin
                    case (k_reg)
                        2'd0:    p_reg <= p_reg + prod_reg[ACC_W-1:0];
                        2'd1:    x_reg <= x_reg + prod_reg[ACC_W-1:0];
                        default: y_reg <= y_reg + prod_reg[ACC_W-1:0];
                    endcase
                    if (metric_reg == MET_PEAR && k_reg == 2'd0)
                    begin
                        n_reg  <= n_reg + 4'd1;
                        sx_reg <= sx_reg + 12'(a_reg);
                        sy_reg <= sy_reg + 12'(b_reg);
                    end
                end
                k_reg <= k_reg + 2'd1;
                if (last_k)
                    row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            ST_POST:
            begin
                step_reg   <= (metric_reg == MET_COS) ? 3'd6 : 3'd0;
                sq_v_reg   <= PROD_W'({x_reg, 24'd0});
                sq_r_reg   <= '0;
                sq_bit_reg <= PROD_W'(1) << (PROD_W - 2);
                if (metric_reg == MET_MAN)
                    res_reg <= RES_W'({x_reg, 12'd0});
                else if (metric_reg != MET_EUC && post_undef)
                    stat_reg <= STAT_UNDEF;
            end
            ST_PMUL: prod_reg <= op_a * op_b;
            ST_PACC:
            begin
                step_reg <= step_reg + 3'd1;
                case (step_reg)
                    3'd0, 3'd2, 3'd4: t_reg <= prod_reg[ACC_W:0];
                    3'd1:    x_reg <= ACC_W'(t_reg - prod_reg[ACC_W:0]);
                    3'd3:    y_reg <= ACC_W'(t_reg - prod_reg[ACC_W:0]);
                    3'd5:
                    begin
                        neg_reg <= prod_reg[ACC_W:0] > t_reg;
                        p_reg   <= (prod_reg[ACC_W:0] > t_reg)
                                   ? ACC_W'(prod_reg[ACC_W:0] - t_reg)
                                   : ACC_W'(t_reg - prod_reg[ACC_W:0]);
                    end
                    default:
                    begin
                        sq_v_reg <= prod_reg;
                        if (pacc_undef)
                            stat_reg <= STAT_UNDEF;
                    end
                endcase
            end
            ST_SQRT:
            begin
                if ({1'b0, sq_v_reg} >= sq_sum)
                begin
                    sq_v_reg <= sq_v_reg - PROD_W'(sq_sum);
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sq_last)
                begin
                    // final root = next sq_r
                    if ({1'b0, sq_v_reg} >= sq_sum)
                    begin
                        res_reg    <= RES_W'((sq_r_reg >> 1) + sq_bit_reg);
                        dv_den_reg <= ACC_W'((sq_r_reg >> 1) + sq_bit_reg);
                    end
                    else
                    begin
                        res_reg    <= RES_W'(sq_r_reg >> 1);
                        dv_den_reg <= ACC_W'(sq_r_reg >> 1);
                    end
                end
                dv_num_reg <= NUM_W'({p_reg, 16'd0});
                dv_rem_reg <= '0;
                dv_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                dv_cnt_reg <= dv_cnt_reg + 6'd1;
                dv_num_reg <= dv_quot;
                if (dv_ge)
                    dv_rem_reg <= ACC_W'(dv_rem2 - {1'b0, dv_den_reg});
                else
                    dv_rem_reg <= ACC_W'(dv_rem2);
                // saturate the final quotient into the result
                if (dv_last)
                begin
                    if (neg_reg)
                        res_reg <= (dv_quot > NUM_W'(1 << (RES_W - 1)))
                                   ? RES_W'(1 << (RES_W - 1))
                                   : RES_W'(-dv_quot);
                    else
                        res_reg <= (dv_quot > NUM_W'((1 << (RES_W - 1)) - 1))
                                   ? RES_W'((1 << (RES_W - 1)) - 1)
                                   : RES_W'(dv_quot);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ src/cse_checker.sv @@
// Port-level checker for column_similarity_engine_unit, with its bind.
// Depends on cse_pkg and column_similarity_engine_unit_macros.svh.
`default_nettype none
`include "column_similarity_engine_unit_macros.svh"
module cse_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic [cse_pkg::IN_W-1:0] s_axis_tdata,
    input wire logic                     s_axis_tuser,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [cse_pkg::OUT_W-1:0] m_axis_tdata
);
    import cse_pkg::*;

    logic [1:0] st;
    assign st = m_axis_tdata[RES_W+1:RES_W];

    `CSE_ASSERT_NOW(a_one_word, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `CSE_ASSERT_NOW(a_status_code, clk, rst_n, m_axis_tvalid, st != 2'd3)
    `CSE_ASSERT_NOW(a_zero_result, clk, rst_n, m_axis_tvalid && (st == STAT_WRITE || st == STAT_UNDEF), m_axis_tdata[RES_W-1:0] == '0)
    `CSE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CSE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind column_similarity_engine_unit cse_checker u_cse_checker (.*);
`default_nettype wire

@@ tb/sv/cse_checker.sv @@
// Checker for the column similarity engine: watches both streams, keeps its
// own rating store, predicts each result word and compares. Depends on cse_pkg.
module cse_tb_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [cse_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [cse_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending,
    output int                        query_count,
    output int                        undef_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import cse_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic [1:0]       stat;
    } sim_word_t;

    logic [RAT_W-1:0] ratings [ROWS][COLS];
    sim_word_t        expected_q [$];

    localparam longint SAT_HI = 64'd67108863;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned rd(int r, int c);
        return (c < COLS) ? ratings[r][c] : 0;
    endfunction

    function automatic longint unsigned clip(longint unsigned v);
        return v > SAT_HI ? SAT_HI : v;
    endfunction

    function automatic sim_word_t similarity(int ca, int cb, logic [1:0] met);
        sim_word_t w;
        longint unsigned a, b, s, p, x, y, n, sx, sy, sxx, syy, sxy, dx, dy, pa, pb, den, q;
        longint signed res;
        w.stat = STAT_OK;
        res = 0;
        s = 0; p = 0; x = 0; y = 0; n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        for (int r = 0; r < ROWS; r++)
        begin
            a = rd(r, ca);
            b = rd(r, cb);
            if (met == MET_MAN)
                s += (a > b) ? a - b : b - a;
            else if (met == MET_EUC)
                s += ((a > b) ? a - b : b - a) * ((a > b) ? a - b : b - a);
            else
            begin
                p += a * b; x += a * a; y += b * b;
                if (a != 0 && b != 0)
                begin
                    n++; sx += a; sy += b; sxx += a * a; syy += b * b; sxy += a * b;
                end
            end
        end
        case (met)
            MET_MAN: res = clip(s << 12);
            MET_EUC: res = clip(int_sqrt(s << 24));
            MET_COS:
                if (x == 0 || y == 0)
                    w.stat = STAT_UNDEF;
                else
                begin
                    den = int_sqrt(x * y);
                    res = (den == 0) ? 0 : clip((p << 16) / den);
                end
            default:
                if (n == 0)
                    w.stat = STAT_UNDEF;
                else
                begin
                    dx = n * sxx - sx * sx;
                    dy = n * syy - sy * sy;
                    pa = n * sxy;
                    pb = sx * sy;
                    if (dx == 0 || dy == 0)
                        w.stat = STAT_UNDEF;
                    else
                    begin
                        den = int_sqrt(dx * dy);
                        q = (den == 0) ? 0 : ((((pb > pa) ? pb - pa : pa - pb)) << 16) / den;
                        if (pb > pa)
                            res = (q > 64'd67108864) ? -64'sd67108864 : -longint'(q);
                        else
                            res = clip(q);
                    end
                end
        endcase
        w.res = res[RES_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sim_word_t w, g;
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    ratings[r][c] = '0;
            expected_q.delete();
            fail_count  <= 0;
            pending     <= 0;
            query_count <= 0;
            undef_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                g.res  = m_tdata[RES_W-1:0];
                g.stat = m_tdata[RES_W+1:RES_W];
                if (expected_q.size() == 0)
                    report_mismatch("unexpected word", g, 0);
                else
                begin
                    w = expected_q.pop_front();
                    if (g.res !== w.res)
                        report_mismatch("result", $signed(g.res), $signed(w.res));
                    if (g.stat !== w.stat)
                        report_mismatch("status", g.stat, w.stat);
                    if (w.stat == STAT_UNDEF)
                        undef_count <= undef_count + 1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                begin
                    ratings[s_tdata[2:0]][s_tdata[5:3]] = s_tdata[16:9];
                    w.res = '0;
                    w.stat = STAT_WRITE;
                end
                else
                begin
                    w = similarity(s_tdata[5:3], s_tdata[8:6], s_tdata[18:17]);
                    query_count <= query_count + 1;
                end
                expected_q = {expected_q, w};
            end
            pending <= expected_q.size();
        end
    end
endmodule

@@ tb/sv/column_similarity_engine_unit_tb.sv @@
// Testbench top for column_similarity_engine_unit: clock, reset, directed and
// random word streams with idle phases. Depends on cse_pkg and cse_tb_checker.
module column_similarity_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cse_pkg::*;

    localparam bit CMD_QUERY = ~CMD_WRITE;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    int                   fail_count, pending, query_count, undef_count;
    int                   send_idle_pct, recv_stall_pct;
    bit                   hold_off;
    longint               cycle_count;

    column_similarity_engine_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    cse_tb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending),
        .query_count(query_count), .undef_count(undef_count)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("timeout");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall, or a long hold-off
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_axis_tready <= 0;
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the accepting
    // edge with tvalid still up, so the next call or drain sets it
    task automatic send_word(bit cmd, int row, int ca, int cb, int rating, int met);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, met[1:0], rating[7:0], cb[2:0], ca[2:0], row[2:0]};
        while (!s_axis_tready)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0 || m_axis_tvalid)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic random_word();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            send_word(CMD_WRITE, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                      ($urandom_range(3) == 0) ? 0 : $urandom_range(255), $urandom_range(3));
        else
            send_word(CMD_QUERY, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                      $urandom_range(255), $urandom_range(3));
    endtask

    initial
    begin
        s_axis_tvalid = 0;
        s_axis_tuser  = 0;
        s_axis_tdata  = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        rst_n = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // empty store: zero distances, undefined cosine and Pearson
        for (int m = 0; m < 4; m++)
            send_word(CMD_QUERY, 0, 0, 7, 0, m);
        // column 0 all max, column 1 mixed, column 2 single co-rated row
        for (int r = 0; r < ROWS; r++)
            send_word(CMD_WRITE, r, 0, 0, 255, 0);
        send_word(CMD_WRITE, 0, 1, 0, 16, 0);
        send_word(CMD_WRITE, 3, 1, 0, 200, 0);
        send_word(CMD_WRITE, 5, 1, 0, 1, 0);
        send_word(CMD_WRITE, 2, 2, 0, 77, 0);
        for (int m = 0; m < 4; m++)
            send_word(CMD_QUERY, 0, 0, 1, 0, m);
        send_word(CMD_QUERY, 7, 0, 2, 255, MET_PEAR);
        send_word(CMD_QUERY, 7, 1, 1, 255, MET_PEAR);
        send_word(CMD_QUERY, 0, 0, 0, 0, MET_COS);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(negedge clk);
                        hold_off = 0;
                    end
                    begin
                        repeat (10) random_word();
                        s_axis_tvalid <= 0;
                        @(negedge clk);
                    end
                join
            end
            for (int i = 0; i < 155; i++)
                random_word();
            drain();
        end

        $display("Covered directed extremes, %0d queries over all four metrics,", query_count);
        $display("%0d undefined results, and five idle and stall phases.", undef_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
